// ===== design/x86il_pkg.sv =====
// Shared types and constants for the 16-bit x86 instruction length decoder.
package x86il_pkg;

    // Longest instruction the decoder collects, in bytes
    localparam logic [2:0] MAX_INSTR_BYTES = 3'd6;

    // Record status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNREC = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Group opcodes that carry a sub-operation in the reg field
    typedef enum logic [1:0] {
        GRP_NONE,
        GRP_SHIFT,
        GRP_F6,
        GRP_FF
    } t_group;

    // Shape of an instruction as told by its opcode byte
    typedef struct packed {
        logic       bad;
        logic       modrm;
        logic [2:0] fixed_len;
        logic [1:0] imm_len;
        logic       imm_sext;
        logic       jump;
        logic       wide;
        t_group     group;
    } t_form;

    // One output record
    typedef struct packed {
        logic [15:0]        start_offset;
        logic [7:0]         opcode;
        logic [2:0]         length;
        logic [1:0]         status;
        logic               has_modrm;
        logic [1:0]         mode_bits;
        logic [2:0]         reg_bits;
        logic [2:0]         rm_bits;
        logic               wide;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
    } t_record;

endpackage

// ===== design/x86il_form.sv =====
// Opcode classifier: length, operand and group information for one opcode byte.
module x86il_form (
    input  logic [7:0]       i_opcode,
    output x86il_pkg::t_form o_form
);

    logic [3:0] w_hi;
    logic [3:0] w_lo;
    logic       w_w;
    logic       w_wb;

    assign w_hi = i_opcode[7:4];
    assign w_lo = i_opcode[3:0];
    assign w_w  = i_opcode[0];
    assign w_wb = i_opcode[3];

    // Decode the opcode map
    always_comb begin
        o_form           = '0;
        o_form.bad       = 1'b1;
        o_form.group     = x86il_pkg::GRP_NONE;
        unique case (w_hi) inside
            [4'h0:4'h3]: begin
                if (i_opcode[2:0] < 3'd4) begin
                    o_form.bad   = 1'b0;
                    o_form.modrm = 1'b1;
                    o_form.wide  = w_w;
                end else if (i_opcode[2:0] < 3'd6) begin
                    o_form.bad       = 1'b0;
                    o_form.fixed_len = 3'd2 + {2'b00, w_w};
                    o_form.imm_len   = 2'd1 + {1'b0, w_w};
                    o_form.imm_sext  = 1'b1;
                    o_form.wide      = w_w;
                end else if (!((i_opcode[5] && !i_opcode[0]) || i_opcode == 8'h0f)) begin
                    o_form.bad       = 1'b0;
                    o_form.fixed_len = 3'd1;
                    o_form.wide      = !(i_opcode[5] && i_opcode[0]);
                end
            end
            [4'h4:4'h5]: begin
                o_form.bad       = 1'b0;
                o_form.fixed_len = 3'd1;
                o_form.wide      = 1'b1;
            end
            4'h6: begin
                o_form.bad = 1'b1;
            end
            4'h7: begin
                o_form.bad       = 1'b0;
                o_form.fixed_len = 3'd2;
                o_form.jump      = 1'b1;
            end
            4'h8: begin
                o_form.bad   = 1'b0;
                o_form.modrm = 1'b1;
                if (w_lo < 4'd4) begin
                    o_form.imm_len  = i_opcode[1] ? 2'd1 : 2'd1 + {1'b0, w_w};
                    o_form.imm_sext = i_opcode[1];
                    o_form.wide     = w_w;
                end else if (w_lo < 4'd12) begin
                    o_form.wide = w_w;
                end else begin
                    o_form.wide = 1'b1;
                end
            end
            4'h9: begin
                if (w_lo != 4'd10) begin
                    o_form.bad       = 1'b0;
                    o_form.fixed_len = 3'd1;
                    o_form.wide      = (w_lo < 4'd8);
                end
            end
            4'ha: begin
                o_form.bad  = 1'b0;
                o_form.wide = w_w;
                case (i_opcode[3:1]) inside
                    3'd0, 3'd1: begin
                        o_form.fixed_len = 3'd3;
                        o_form.imm_len   = 2'd2;
                    end
                    3'd4: begin
                        o_form.fixed_len = 3'd2 + {2'b00, w_w};
                        o_form.imm_len   = 2'd1 + {1'b0, w_w};
                    end
                    default: begin
                        o_form.fixed_len = 3'd1;
                    end
                endcase
            end
            4'hb: begin
                o_form.bad       = 1'b0;
                o_form.fixed_len = 3'd2 + {2'b00, w_wb};
                o_form.imm_len   = 2'd1 + {1'b0, w_wb};
                o_form.imm_sext  = 1'b1;
                o_form.wide      = w_wb;
            end
            4'hc: begin
                case (w_lo) inside
                    4'd2, 4'd10: begin
                        o_form.bad       = 1'b0;
                        o_form.fixed_len = 3'd3;
                        o_form.imm_len   = 2'd2;
                        o_form.wide      = 1'b1;
                    end
                    4'd3, 4'd11, 4'd12, 4'd14, 4'd15: begin
                        o_form.bad       = 1'b0;
                        o_form.fixed_len = 3'd1;
                    end
                    4'd4, 4'd5: begin
                        o_form.bad   = 1'b0;
                        o_form.modrm = 1'b1;
                        o_form.wide  = 1'b1;
                    end
                    4'd6: begin
                        o_form.bad      = 1'b0;
                        o_form.modrm    = 1'b1;
                        o_form.imm_len  = 2'd1;
                        o_form.imm_sext = 1'b1;
                    end
                    4'd7: begin
                        o_form.bad     = 1'b0;
                        o_form.modrm   = 1'b1;
                        o_form.imm_len = 2'd2;
                        o_form.wide    = 1'b1;
                    end
                    4'd13: begin
                        o_form.bad       = 1'b0;
                        o_form.fixed_len = 3'd2;
                        o_form.imm_len   = 2'd1;
                    end
                    default: begin
                        o_form.bad = 1'b1;
                    end
                endcase
            end
            4'hd: begin
                if (w_lo < 4'd4) begin
                    o_form.bad   = 1'b0;
                    o_form.modrm = 1'b1;
                    o_form.wide  = w_w;
                    o_form.group = x86il_pkg::GRP_SHIFT;
                end else if (w_lo == 4'd4 || w_lo == 4'd5) begin
                    o_form.bad       = 1'b0;
                    o_form.fixed_len = 3'd2;
                    o_form.imm_len   = 2'd1;
                end else if (w_lo == 4'd7) begin
                    o_form.bad       = 1'b0;
                    o_form.fixed_len = 3'd1;
                end
            end
            4'he: begin
                if (w_lo < 4'd4) begin
                    o_form.bad       = 1'b0;
                    o_form.fixed_len = 3'd2;
                    o_form.jump      = 1'b1;
                end else if (w_lo < 4'd8) begin
                    o_form.bad       = 1'b0;
                    o_form.fixed_len = 3'd2;
                    o_form.imm_len   = 2'd1;
                    o_form.wide      = w_w;
                end else if (w_lo >= 4'd12) begin
                    o_form.bad       = 1'b0;
                    o_form.fixed_len = 3'd1;
                    o_form.wide      = w_w;
                end
            end
            default: begin
                case (w_lo) inside
                    4'd1: begin
                        o_form.bad = 1'b1;
                    end
                    4'd6, 4'd7: begin
                        o_form.bad   = 1'b0;
                        o_form.modrm = 1'b1;
                        o_form.wide  = w_w;
                        o_form.group = x86il_pkg::GRP_F6;
                    end
                    4'd14: begin
                        o_form.bad   = 1'b0;
                        o_form.modrm = 1'b1;
                    end
                    4'd15: begin
                        o_form.bad   = 1'b0;
                        o_form.modrm = 1'b1;
                        o_form.wide  = 1'b1;
                        o_form.group = x86il_pkg::GRP_FF;
                    end
                    default: begin
                        o_form.bad       = 1'b0;
                        o_form.fixed_len = 3'd1;
                    end
                endcase
            end
        endcase
    end

endmodule

// ===== design/x86il_core.sv =====
// Byte collector: holds the bytes of one instruction and builds its record.
module x86il_core #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [7:0]           i_byte,
    input  logic                 i_eos,
    output logic                 o_res_valid,
    output x86il_pkg::t_record   o_rec
);

    logic [2:0]             r_cnt;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_stopped;
    logic [7:0]             r_prev;
    logic [7:0]             r_held [4];

    x86il_pkg::t_form       w_f;
    logic [7:0]             w_op;
    logic [7:0]             w_mb;
    logic [7:0]             w_b2;
    logic [7:0]             w_b3;
    logic [7:0]             w_jmp;
    logic [2:0]             w_cnt_new;
    logic [2:0]             w_need;
    logic [1:0]             w_dlen;
    logic [1:0]             w_imm_len;
    logic                   w_have_m;
    logic [1:0]             w_mod;
    logic [2:0]             w_reg;
    logic [2:0]             w_rm;
    logic                   w_bad;
    logic                   w_ok;
    logic [15:0]            w_disp;
    logic [15:0]            w_imm;
    logic [OFFSET_BITS-1:0] w_start;

    // Merge the incoming byte into the fixed byte positions
    assign w_op      = (r_cnt == 3'd0) ? i_byte : r_held[0];
    assign w_mb      = (r_cnt == 3'd1) ? i_byte : r_held[1];
    assign w_b2      = (r_cnt == 3'd2) ? i_byte : r_held[2];
    assign w_b3      = (r_cnt == 3'd3) ? i_byte : r_held[3];
    assign w_jmp     = w_mb + 8'd2;
    assign w_cnt_new = r_cnt + 3'd1;
    assign w_start   = r_offset - OFFSET_BITS'(r_cnt);

    x86il_form u_form (
        .i_opcode (w_op),
        .o_form   (w_f)
    );

    // Work out the needed length and whether the instruction ends here
    always_comb begin
        w_have_m  = 1'b0;
        w_mod     = 2'd0;
        w_reg     = 3'd0;
        w_rm      = 3'd0;
        w_need    = 3'd0;
        w_bad     = 1'b0;
        w_dlen    = 2'd0;
        w_imm_len = w_f.imm_len;
        if (w_f.bad) begin
            w_bad = 1'b1;
        end else if (!w_f.modrm) begin
            w_need = w_f.fixed_len;
        end else if (w_cnt_new >= 3'd2) begin
            w_have_m = 1'b1;
            w_mod    = w_mb[7:6];
            w_reg    = w_mb[5:3];
            w_rm     = w_mb[2:0];
            if (w_mod == 2'd1) begin
                w_dlen = 2'd1;
            end else if (w_mod == 2'd2 || (w_mod == 2'd0 && w_rm == 3'd6)) begin
                w_dlen = 2'd2;
            end
            if ((w_f.group == x86il_pkg::GRP_SHIFT && w_reg == 3'd6) ||
                (w_f.group == x86il_pkg::GRP_F6 && w_reg == 3'd1) ||
                (w_f.group == x86il_pkg::GRP_FF && w_reg == 3'd7)) begin
                w_bad = 1'b1;
            end else begin
                if (w_f.group == x86il_pkg::GRP_F6) begin
                    w_imm_len = (w_reg == 3'd0) ? 2'd1 + {1'b0, w_f.wide} : 2'd0;
                end
                w_need = 3'd2 + {1'b0, w_dlen} + {1'b0, w_imm_len};
            end
        end
        w_ok = !w_bad && (w_need != 3'd0) && (w_cnt_new >= w_need);
    end

    // Pick displacement and immediate; the immediate is always the last bytes
    always_comb begin
        w_disp = 16'd0;
        w_imm  = 16'd0;
        if (w_ok) begin
            if (w_f.modrm) begin
                if (w_dlen == 2'd1) begin
                    w_disp = {{8{w_b2[7]}}, w_b2};
                end else if (w_dlen == 2'd2) begin
                    w_disp = {w_b3, w_b2};
                end
            end else if (w_f.jump) begin
                w_disp = {{8{w_jmp[7]}}, w_jmp};
            end
            if (w_imm_len == 2'd1) begin
                w_imm = w_f.imm_sext ? {{8{i_byte[7]}}, i_byte} : {8'h00, i_byte};
            end else if (w_imm_len == 2'd2) begin
                w_imm = {i_byte, r_prev};
            end
        end
    end

    // Build the record
    assign o_res_valid = i_go && !r_stopped && (w_bad || w_ok || i_eos);

    always_comb begin
        o_rec.start_offset = 16'(w_start);
        o_rec.opcode       = w_op;
        o_rec.length       = w_cnt_new;
        o_rec.status       = w_bad ? x86il_pkg::ST_UNREC :
                             (w_ok ? x86il_pkg::ST_OK : x86il_pkg::ST_TRUNC);
        o_rec.has_modrm    = w_have_m;
        o_rec.mode_bits    = w_mod;
        o_rec.reg_bits     = w_reg;
        o_rec.rm_bits      = w_rm;
        o_rec.wide         = w_f.wide;
        o_rec.displacement = w_disp;
        o_rec.immediate    = w_imm;
    end

    // Advance the collection state by one byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= 3'd0;
            r_offset  <= '0;
            r_stopped <= 1'b0;
        end else if (i_go) begin
            if (r_stopped) begin
                r_cnt <= 3'd0;
                if (i_eos) begin
                    r_stopped <= 1'b0;
                    r_offset  <= '0;
                end else begin
                    r_offset <= r_offset + OFFSET_BITS'(1);
                end
            end else if (o_res_valid) begin
                r_cnt <= 3'd0;
                if (i_eos) begin
                    r_offset  <= '0;
                    r_stopped <= 1'b0;
                end else begin
                    r_offset  <= r_offset + OFFSET_BITS'(1);
                    r_stopped <= !w_ok;
                end
            end else begin
                r_cnt    <= w_cnt_new;
                r_offset <= r_offset + OFFSET_BITS'(1);
            end
        end
    end

    // Hold the instruction bytes; no reset needed
    always_ff @(posedge i_clk) begin
        if (i_go && !r_stopped) begin
            r_prev <= i_byte;
            for (int k = 0; k < 4; k++) begin
                if (r_cnt == 3'(k)) begin
                    r_held[k] <= i_byte;
                end
            end
        end
    end

endmodule

// ===== design/x86_16bit_instruction_length_decoder.sv =====
// A byte's record passes through the input register and then the result register.
// One byte per cycle unless stalled; at most one record per byte, held during a stall.
// The input register advances whenever the result register is free or being taken.
// Reset (synchronous, active low) clears both valid flags, the byte count, the stream
// offset and the stopped flag; held instruction bytes are not cleared.
module x86_16bit_instruction_length_decoder #(
    parameter int OFFSET_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_byte_value,
    input  logic               i_end_of_stream,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_start_offset,
    output logic [7:0]         o_opcode,
    output logic [2:0]         o_length,
    output logic [1:0]         o_status,
    output logic               o_has_modrm,
    output logic [1:0]         o_mode_bits,
    output logic [2:0]         o_reg_bits,
    output logic [2:0]         o_rm_bits,
    output logic               o_wide,
    output logic signed [15:0] o_displacement,
    output logic [15:0]        o_immediate
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_eos;
    logic               r_out_valid;
    x86il_pkg::t_record r_out_rec;

    logic               w_adv;
    logic               w_go;
    logic               w_res_valid;
    x86il_pkg::t_record w_rec;

    assign w_adv   = !r_out_valid || !i_stall;
    assign w_go    = r_in_valid && w_adv;
    assign o_stall = r_in_valid && !w_adv;

    // Take a word whenever the input register is free or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_byte_value;
            r_in_eos  <= i_end_of_stream;
        end
    end

    x86il_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_byte      (r_in_byte),
        .i_eos       (r_in_eos),
        .o_res_valid (w_res_valid),
        .o_rec       (w_rec)
    );

    // Load the result register when it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_go && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_res_valid) begin
            r_out_rec <= w_rec;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_start_offset = r_out_rec.start_offset;
    assign o_opcode       = r_out_rec.opcode;
    assign o_length       = r_out_rec.length;
    assign o_status       = r_out_rec.status;
    assign o_has_modrm    = r_out_rec.has_modrm;
    assign o_mode_bits    = r_out_rec.mode_bits;
    assign o_reg_bits     = r_out_rec.reg_bits;
    assign o_rm_bits      = r_out_rec.rm_bits;
    assign o_wide         = r_out_rec.wide;
    assign o_displacement = r_out_rec.displacement;
    assign o_immediate    = r_out_rec.immediate;

    // Record length stays within one instruction
    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_length != 3'd0 && o_length <= x86il_pkg::MAX_INSTR_BYTES))
        else $error("record length out of range");

    // A record carrying a mod-reg-rm byte spans at least two bytes
    a_modrm_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_modrm) |-> (o_length >= 3'd2))
        else $error("mod-reg-rm record shorter than two bytes");

    // Error records carry no displacement and no immediate
    a_err_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != x86il_pkg::ST_OK) |-> (o_displacement == 16'sd0 &&
            o_immediate == 16'd0))
        else $error("error record with operand data");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == x86il_pkg::ST_OK || o_status == x86il_pkg::ST_UNREC ||
            o_status == x86il_pkg::ST_TRUNC))
        else $error("undefined status code");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the 16-bit x86 instruction length decoder.
module tb;

    // Run limits
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 8;

    // Opcodes used by the directed tests
    localparam logic [7:0] OP_ADD_AX_IMM   = 8'h05;
    localparam logic [7:0] OP_TWO_BYTE     = 8'h0f;
    localparam logic [7:0] OP_JG_SHORT     = 8'h7f;
    localparam logic [7:0] OP_GRP1_IMM16   = 8'h81;
    localparam logic [7:0] OP_MOV_FROM_SEG = 8'h8c;
    localparam logic [7:0] OP_NOP          = 8'h90;
    localparam logic [7:0] OP_SHIFT_BY_ONE = 8'hd0;
    localparam logic [7:0] OP_GRP_F6       = 8'hf6;
    localparam logic [7:0] OP_GRP_FE       = 8'hfe;

    // Sub-operations and addressing fields
    localparam logic [2:0] SUB_SHIFT_BAD = 3'd6;
    localparam logic [2:0] SUB_F6_TEST   = 3'd0;
    localparam logic [2:0] SUB_F6_BAD    = 3'd1;
    localparam logic [2:0] SUB_FF_BAD    = 3'd7;
    localparam logic [1:0] MOD_MEM       = 2'd0;
    localparam logic [1:0] MOD_DISP8     = 2'd1;
    localparam logic [1:0] MOD_DISP16    = 2'd2;
    localparam logic [2:0] RM_DIRECT     = 3'd6;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_byte_value;
    logic               i_end_of_stream;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [15:0]        o_start_offset;
    logic [7:0]         o_opcode;
    logic [2:0]         o_length;
    logic [1:0]         o_status;
    logic               o_has_modrm;
    logic [1:0]         o_mode_bits;
    logic [2:0]         o_reg_bits;
    logic [2:0]         o_rm_bits;
    logic               o_wide;
    logic signed [15:0] o_displacement;
    logic [15:0]        o_immediate;

    // Decoder copy: bytes of the instruction in progress and stream position
    logic [7:0]  frag_bytes [x86il_pkg::MAX_INSTR_BYTES];
    int          frag_count  = 0;
    logic [15:0] next_offset = '0;
    bit          dropping    = 1'b0;

    x86il_pkg::t_record pending_records [$];
    x86il_pkg::t_record got_rec;
    x86il_pkg::t_record want_rec;

    // Instruction under construction by the stimulus
    logic [7:0]  instr_bytes [x86il_pkg::MAX_INSTR_BYTES];
    int          instr_len;

    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    int          stall_left   = 0;
    int          cycle_count  = 0;
    int          errors       = 0;
    int          decoded_bytes   = 0;
    int          records_checked = 0;
    int          streams_sent    = 0;

    x86_16bit_instruction_length_decoder #(
        .OFFSET_BITS(16)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_value   (i_byte_value),
        .i_end_of_stream(i_end_of_stream),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_start_offset (o_start_offset),
        .o_opcode       (o_opcode),
        .o_length       (o_length),
        .o_status       (o_status),
        .o_has_modrm    (o_has_modrm),
        .o_mode_bits    (o_mode_bits),
        .o_reg_bits     (o_reg_bits),
        .o_rm_bits      (o_rm_bits),
        .o_wide         (o_wide),
        .o_displacement (o_displacement),
        .o_immediate    (o_immediate)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Shape of an opcode without a mod-reg-rm byte
    function automatic x86il_pkg::t_form plain_form(int len, int imm, bit sx, bit w);
        x86il_pkg::t_form f;
        f           = '0;
        f.group     = x86il_pkg::GRP_NONE;
        f.fixed_len = 3'(len);
        f.imm_len   = 2'(imm);
        f.imm_sext  = sx;
        f.wide      = w;
        return f;
    endfunction

    // Shape of an opcode that carries a mod-reg-rm byte
    function automatic x86il_pkg::t_form modrm_form(int imm, bit sx, bit w,
                                                    x86il_pkg::t_group g);
        x86il_pkg::t_form f;
        f          = '0;
        f.modrm    = 1'b1;
        f.imm_len  = 2'(imm);
        f.imm_sext = sx;
        f.wide     = w;
        f.group    = g;
        return f;
    endfunction

    // Opcode table, rows keyed by high nibble
    function automatic x86il_pkg::t_form opcode_form(logic [7:0] op);
        x86il_pkg::t_form f;
        logic  w;
        int    lo;
        w       = op[0];
        lo      = op[3:0];
        f       = '0;
        f.bad   = 1'b1;
        f.group = x86il_pkg::GRP_NONE;
        case (op[7:4])
            4'h0, 4'h1, 4'h2, 4'h3: begin
                if (op[2:0] < 3'd4) f = modrm_form(0, 0, w, x86il_pkg::GRP_NONE);
                else if (op[2:0] < 3'd6) f = plain_form(2 + w, 1 + w, 1, w);
                else if ((op & 8'h21) != 8'h20 && op != OP_TWO_BYTE)
                    f = plain_form(1, 0, 0, (op & 8'h21) != 8'h21);
            end
            4'h4, 4'h5: f = plain_form(1, 0, 0, 1);
            4'h6: ;
            4'h7: begin
                f      = plain_form(2, 0, 0, 0);
                f.jump = 1'b1;
            end
            4'h8: begin
                if (lo < 4) f = modrm_form(op[1] ? 1 : 1 + w, op[1], w, x86il_pkg::GRP_NONE);
                else if (lo < 12) f = modrm_form(0, 0, w, x86il_pkg::GRP_NONE);
                else f = modrm_form(0, 0, 1, x86il_pkg::GRP_NONE);
            end
            4'h9: begin
                if (lo != 10) f = plain_form(1, 0, 0, lo < 8);
            end
            4'ha: begin
                case (op[3:1])
                    3'd0, 3'd1: f = plain_form(3, 2, 0, w);
                    3'd4:       f = plain_form(2 + w, 1 + w, 0, w);
                    default:    f = plain_form(1, 0, 0, w);
                endcase
            end
            4'hb: f = plain_form(2 + op[3], 1 + op[3], 1, op[3]);
            4'hc: begin
                case (lo)
                    2, 10:              f = plain_form(3, 2, 0, 1);
                    3, 11, 12, 14, 15:  f = plain_form(1, 0, 0, 0);
                    4, 5:               f = modrm_form(0, 0, 1, x86il_pkg::GRP_NONE);
                    6:                  f = modrm_form(1, 1, 0, x86il_pkg::GRP_NONE);
                    7:                  f = modrm_form(2, 0, 1, x86il_pkg::GRP_NONE);
                    13:                 f = plain_form(2, 1, 0, 0);
                    default: ;
                endcase
            end
            4'hd: begin
                if (lo < 4) f = modrm_form(0, 0, w, x86il_pkg::GRP_SHIFT);
                else if (lo == 4 || lo == 5) f = plain_form(2, 1, 0, 0);
                else if (lo == 7) f = plain_form(1, 0, 0, 0);
            end
            4'he: begin
                if (lo < 4) begin
                    f      = plain_form(2, 0, 0, 0);
                    f.jump = 1'b1;
                end else if (lo < 8) f = plain_form(2, 1, 0, w);
                else if (lo >= 12) f = plain_form(1, 0, 0, w);
            end
            default: begin
                if (lo == 6 || lo == 7) f = modrm_form(0, 0, w, x86il_pkg::GRP_F6);
                else if (lo == 14) f = modrm_form(0, 0, 0, x86il_pkg::GRP_NONE);
                else if (lo == 15) f = modrm_form(0, 0, 1, x86il_pkg::GRP_FF);
                else if (lo != 1) f = plain_form(1, 0, 0, 0);
            end
        endcase
        return f;
    endfunction

    function automatic bit bad_subop(x86il_pkg::t_group g, logic [2:0] sub);
        return (g == x86il_pkg::GRP_SHIFT && sub == SUB_SHIFT_BAD) ||
               (g == x86il_pkg::GRP_F6 && sub == SUB_F6_BAD) ||
               (g == x86il_pkg::GRP_FF && sub == SUB_FF_BAD);
    endfunction

    function automatic int disp_len(logic [1:0] mode, logic [2:0] rm);
        if (mode == MOD_DISP8) return 1;
        if (mode == MOD_DISP16 || (mode == MOD_MEM && rm == RM_DIRECT)) return 2;
        return 0;
    endfunction

    // Only the test sub-operation of the F6/F7 group takes an immediate
    function automatic int operand_imm_len(x86il_pkg::t_form f, logic [2:0] sub);
        if (f.group == x86il_pkg::GRP_F6) return (sub == SUB_F6_TEST) ? 1 + f.wide : 0;
        return f.imm_len;
    endfunction

    function automatic int modrm_length(x86il_pkg::t_form f, logic [7:0] m);
        return 2 + disp_len(m[7:6], m[2:0]) + operand_imm_len(f, m[5:3]);
    endfunction

    function automatic logic [15:0] read_immediate(int p, int len, bit sx);
        if (len == 1) return sx ? {{8{frag_bytes[p][7]}}, frag_bytes[p]} : {8'h00, frag_bytes[p]};
        if (len == 2) return {frag_bytes[p + 1], frag_bytes[p]};
        return '0;
    endfunction

    // Advance the decoder copy by one accepted word; queue the record it completes
    task automatic predict_byte(input logic [7:0] b, input logic eos);
        x86il_pkg::t_form   f;
        x86il_pkg::t_record rec;
        int         need;
        int         imm_len;
        int         dl;
        bit         emit;
        logic [1:0] st;
        logic [7:0] m;
        logic [7:0] jmp;
        if (dropping) begin
            if (eos) begin
                dropping    = 1'b0;
                next_offset = '0;
            end else begin
                next_offset++;
            end
            frag_count = 0;
            return;
        end
        decoded_bytes++;
        if (frag_count >= x86il_pkg::MAX_INSTR_BYTES) frag_count = 0;
        frag_bytes[frag_count] = b;
        frag_count++;
        rec              = '0;
        rec.start_offset = next_offset - 16'(frag_count - 1);
        rec.opcode       = frag_bytes[0];
        rec.length       = 3'(frag_count);
        f                = opcode_form(frag_bytes[0]);
        rec.wide         = f.wide;
        imm_len          = f.imm_len;
        need             = 0;
        emit             = 1'b0;
        st               = x86il_pkg::ST_OK;
        m                = '0;
        if (f.bad) begin
            emit = 1'b1;
            st   = x86il_pkg::ST_UNREC;
        end else if (!f.modrm) begin
            need = f.fixed_len;
        end else if (frag_count >= 2) begin
            m             = frag_bytes[1];
            rec.has_modrm = 1'b1;
            rec.mode_bits = m[7:6];
            rec.reg_bits  = m[5:3];
            rec.rm_bits   = m[2:0];
            if (bad_subop(f.group, m[5:3])) begin
                emit = 1'b1;
                st   = x86il_pkg::ST_UNREC;
            end else begin
                imm_len = operand_imm_len(f, m[5:3]);
                need    = modrm_length(f, m);
            end
        end
        if (!emit) begin
            if (need != 0 && frag_count >= need) begin
                emit = 1'b1;
                st   = x86il_pkg::ST_OK;
            end else if (eos) begin
                emit = 1'b1;
                st   = x86il_pkg::ST_TRUNC;
            end
        end
        if (!emit) begin
            next_offset++;
            return;
        end
        rec.status = st;
        // Operands are only reported for complete instructions
        if (st == x86il_pkg::ST_OK) begin
            if (f.modrm) begin
                dl = disp_len(m[7:6], m[2:0]);
                if (dl == 1) rec.displacement = {{8{frag_bytes[2][7]}}, frag_bytes[2]};
                else if (dl == 2) rec.displacement = {frag_bytes[3], frag_bytes[2]};
                rec.immediate = read_immediate(2 + dl, imm_len, f.imm_sext);
            end else if (f.jump) begin
                jmp              = frag_bytes[1] + 8'd2;
                rec.displacement = {{8{jmp[7]}}, jmp};
            end else begin
                rec.immediate = read_immediate(1, imm_len, f.imm_sext);
            end
        end
        pending_records.push_back(rec);
        frag_count = 0;
        if (eos) begin
            next_offset = '0;
            dropping    = 1'b0;
        end else begin
            next_offset++;
            dropping = (st != x86il_pkg::ST_OK);
        end
    endtask

    // Offer one word, hold it until taken, then update the decoder copy
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        @(negedge i_clk);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap     = $urandom_range(1, 9);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_byte_value    = b;
        i_end_of_stream = eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(b, eos);
    endtask

    // Build one instruction; clean ones have a known opcode and a legal sub-operation
    task automatic make_instruction(input bit clean);
        x86il_pkg::t_form f;
        logic [7:0] op;
        do begin
            op = 8'($urandom_range(0, 255));
            f  = opcode_form(op);
        end while (f.bad && (clean || $urandom_range(0, 3) != 0));
        instr_bytes[0] = op;
        for (int j = 1; j < x86il_pkg::MAX_INSTR_BYTES; j++)
            instr_bytes[j] = 8'($urandom_range(0, 255));
        if (f.bad) begin
            instr_len = 1;
        end else if (!f.modrm) begin
            instr_len = f.fixed_len;
        end else begin
            while ((clean || $urandom_range(0, 3) != 0) && bad_subop(f.group, instr_bytes[1][5:3]))
                instr_bytes[1] = 8'($urandom_range(0, 255));
            instr_len = bad_subop(f.group, instr_bytes[1][5:3]) ? 2 : modrm_length(f, instr_bytes[1]);
        end
    endtask

    // One stream: mostly whole instructions, sometimes cut short or pure noise
    task automatic send_random_stream();
        int n;
        int cut;
        bit last;
        streams_sent++;
        if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)), k == n - 1);
            return;
        end
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            make_instruction(1'b0);
            last = (k == n - 1);
            cut  = instr_len;
            if (last && instr_len > 1 && $urandom_range(0, 5) == 0)
                cut = $urandom_range(1, instr_len - 1);
            for (int j = 0; j < cut; j++) send_byte(instr_bytes[j], last && j == cut - 1);
        end
    endtask

    task automatic test_directed_forms();
        streams_sent++;
        // segment move with an 8-bit displacement of -128
        send_byte(OP_MOV_FROM_SEG, 1'b0);
        send_byte(8'h46, 1'b0);
        send_byte(8'h80, 1'b0);
        // short jump whose offset plus two wraps to 0x80
        send_byte(OP_JG_SHORT, 1'b0);
        send_byte(8'h7e, 1'b0);
        // group FE accepts sub-operation 7
        send_byte(OP_GRP_FE, 1'b0);
        send_byte(8'hf8, 1'b0);
        // six-byte form: 16-bit displacement and 16-bit immediate, all ones
        send_byte(OP_GRP1_IMM16, 1'b0);
        send_byte(8'h86, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    task automatic test_group_suboperations();
        streams_sent++;
        // test sub-operation takes an 8-bit immediate
        send_byte(OP_GRP_F6, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        // invalid shift sub-operation, then a dropped word ending the stream
        send_byte(OP_SHIFT_BY_ONE, 1'b0);
        send_byte(8'hf0, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_error_paths();
        // unknown opcode on the last word: unrecognized wins over truncated
        streams_sent++;
        send_byte(OP_TWO_BYTE, 1'b1);
        // stream ends inside an immediate
        streams_sent++;
        send_byte(OP_ADD_AX_IMM, 1'b0);
        send_byte(8'h34, 1'b1);
        // single-word stream
        streams_sent++;
        send_byte(OP_NOP, 1'b1);
    endtask

    task automatic test_random_streams(input int target, input bit idling);
        int start;
        src_idle_on  = idling;
        sink_idle_on = idling;
        start        = decoded_bytes;
        while (decoded_bytes - start < target) send_random_stream();
    endtask

    // Receiver stalls in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            i_stall    = 1'b1;
            stall_left = $urandom_range(1, 9) - 1;
        end else begin
            i_stall = 1'b0;
        end
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each taken record with the oldest one queued
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_rec.start_offset = o_start_offset;
            got_rec.opcode       = o_opcode;
            got_rec.length       = o_length;
            got_rec.status       = o_status;
            got_rec.has_modrm    = o_has_modrm;
            got_rec.mode_bits    = o_mode_bits;
            got_rec.reg_bits     = o_reg_bits;
            got_rec.rm_bits      = o_rm_bits;
            got_rec.wide         = o_wide;
            got_rec.displacement = o_displacement;
            got_rec.immediate    = o_immediate;
            if (pending_records.size() == 0) begin
                $display("%0t: unexpected record, expected none, actual opcode %0h offset %0h",
                         $time, got_rec.opcode, got_rec.start_offset);
                errors++;
            end else begin
                want_rec = pending_records.pop_front();
                check_field("start_offset", want_rec.start_offset, got_rec.start_offset);
                check_field("opcode", want_rec.opcode, got_rec.opcode);
                check_field("length", want_rec.length, got_rec.length);
                check_field("status", want_rec.status, got_rec.status);
                check_field("has_modrm", want_rec.has_modrm, got_rec.has_modrm);
                check_field("mode_bits", want_rec.mode_bits, got_rec.mode_bits);
                check_field("reg_bits", want_rec.reg_bits, got_rec.reg_bits);
                check_field("rm_bits", want_rec.rm_bits, got_rec.rm_bits);
                check_field("wide", want_rec.wide, got_rec.wide);
                check_field("displacement", want_rec.displacement, got_rec.displacement);
                check_field("immediate", want_rec.immediate, got_rec.immediate);
                records_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sequence the tests
    initial begin
        i_valid         = 1'b0;
        i_byte_value    = '0;
        i_end_of_stream = 1'b0;
        i_rst_n         = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_forms();
        test_group_suboperations();
        test_error_paths();
        test_random_streams(1000, 1'b1);
        test_random_streams(200, 1'b0);

        // Drain outstanding records, then watch for strays
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Decoded %0d bytes over %0d streams and checked %0d records.",
                 decoded_bytes, streams_sent, records_checked);
        $display("Covered error recovery, truncation, group sub-operations and stalls.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/x86il_pkg.sv
design/x86il_form.sv
design/x86il_core.sv
design/x86_16bit_instruction_length_decoder.sv
bench/tb.sv
